// ----- sv/prct_pkg.sv -----
// ----------------------------------------------------------------------------
// prct_pkg
// Shared sizes and types of the persistent range count tree.
// ----------------------------------------------------------------------------
package prct_pkg;

   localparam int MAX_ITEMS  = 1024;
   localparam int VALUE_BITS = 16;
   localparam int POOL_SIZE  = 1 + MAX_ITEMS * (VALUE_BITS + 1);
   localparam int NODE_BITS  = $clog2(POOL_SIZE);
   localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
   localparam int ROOT_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int DEPTH_BITS = $clog2(VALUE_BITS + 1);

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef struct packed {
      logic [NODE_BITS-1:0] left;
      logic [NODE_BITS-1:0] right;
      logic [CNT_BITS-1:0]  count;
   } node_type;

endpackage

// ----- sv/prct_node_ram.sv -----
// ----------------------------------------------------------------------------
// prct_node_ram
// Node pool: one write port, one registered read port; node 0 reads as zero.
// ----------------------------------------------------------------------------
module prct_node_ram (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [prct_pkg::NODE_BITS-1:0] rd_addr,
   output prct_pkg::node_type             rd_data,
   input  logic                           wr_en,
   input  logic [prct_pkg::NODE_BITS-1:0] wr_addr,
   input  prct_pkg::node_type             wr_data
);

   prct_pkg::node_type mem [prct_pkg::POOL_SIZE];
   prct_pkg::node_type q_ff;
   logic               zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff    <= mem[rd_addr];
         zero_ff <= (rd_addr == '0);
      end
   end

   assign rd_data = zero_ff ? '0 : q_ff;

endmodule

// ----- sv/persistent_range_count_tree_top.sv -----
// ----------------------------------------------------------------------------
// persistent_range_count_tree_top
// Persistent count tree: appends copy a root-to-leaf path, queries walk two
// versions side by side and count values above a threshold.
// ----------------------------------------------------------------------------
// One beat at a time. An append does one node read and one write per level on
// the node pool port; a query reads the two version paths through the single
// node read port. Full-sequence and bad-range beats go straight from idle to
// the response state. No clearing pass after reset.
module persistent_range_count_tree_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_item_value,
   input  logic [9:0]  req_range_start,
   input  logic [9:0]  req_range_end,
   input  logic [15:0] req_threshold,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_count,
   output logic [1:0]  rsp_status
);

   localparam int NB = prct_pkg::NODE_BITS;
   localparam int CB = prct_pkg::CNT_BITS;
   localparam int RB = prct_pkg::ROOT_BITS;
   localparam int DB = prct_pkg::DEPTH_BITS;
   localparam int VB = prct_pkg::VALUE_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_AROOT, S_AW, S_QROOT, S_QNA, S_QNB, S_QCALC, S_OUT
   } state_type;

   state_type          state_ff;
   logic [CB-1:0]      items_ff;
   logic [NB-1:0]      next_free_ff;
   logic [NB-1:0]      cur_ff;
   logic [NB-1:0]      a_idx_ff;
   logic [NB-1:0]      b_idx_ff;
   prct_pkg::node_type a_data_ff;
   logic [VB-1:0]      val_ff;
   logic [DB-1:0]      depth_ff;
   logic               prev_bit_ff;
   logic [CB-1:0]      acc_ff;
   logic [CB-1:0]      res_count_ff;
   logic [1:0]         res_status_ff;
   logic [RB-1:0]      hi_ff;
   logic               rsp_valid_ff;
   logic [10:0]        rsp_count_ff;
   logic [1:0]         rsp_status_ff;

   logic [NB-1:0] root_mem [prct_pkg::MAX_ITEMS + 1];
   logic [NB-1:0] root_q_ff;
   logic          root_zero_ff;
   logic          root_rd_en;
   logic [RB-1:0] root_rd_addr;
   logic          root_wr_en;
   logic [NB-1:0] root_eff;

   logic               nd_rd_en;
   logic [NB-1:0]      nd_rd_addr;
   prct_pkg::node_type nd_rd_data;
   logic               nd_wr_en;
   prct_pkg::node_type nd_wr_data;

   logic          accept;
   logic          bit_now;
   logic [CB-1:0] diff;
   logic [CB-1:0] acc_in;
   logic          last_lvl;
   logic          q_bad;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign root_eff = root_zero_ff ? '0 : root_q_ff;
   assign bit_now  = val_ff[VB-1];
   assign last_lvl = (depth_ff == DB'(VB));
   assign diff     = nd_rd_data.count - a_data_ff.count;
   assign q_bad    = (req_range_start > req_range_end)
                     || ({1'b0, req_range_end} >= items_ff);

   always_comb begin
      acc_in = acc_ff;
      if ((depth_ff != '0) && !prev_bit_ff) begin
         acc_in = acc_in - diff;
      end
      if (!last_lvl && !bit_now) begin
         acc_in = acc_in + diff;
      end
   end

   always_comb begin
      root_rd_en   = 1'b0;
      root_rd_addr = RB'(items_ff);
      root_wr_en   = 1'b0;
      nd_rd_en     = 1'b0;
      nd_rd_addr   = a_idx_ff;
      nd_wr_en     = 1'b0;
      nd_wr_data   = '0;
      case (state_ff)
         S_IDLE: begin
            root_rd_en   = accept;
            root_rd_addr = (req_type == prct_pkg::REQ_QUERY)
                           ? RB'(req_range_start) : RB'(items_ff);
         end
         S_AROOT: begin
            root_wr_en = 1'b1;
            nd_rd_en   = 1'b1;
            nd_rd_addr = root_eff;
         end
         S_AW: begin
            nd_wr_en = 1'b1;
            nd_wr_data.count = nd_rd_data.count + 1'b1;
            if (!last_lvl) begin
               nd_rd_en = 1'b1;
               if (bit_now) begin
                  nd_wr_data.left  = nd_rd_data.left;
                  nd_wr_data.right = cur_ff + 1'b1;
                  nd_rd_addr       = nd_rd_data.right;
               end else begin
                  nd_wr_data.left  = cur_ff + 1'b1;
                  nd_wr_data.right = nd_rd_data.right;
                  nd_rd_addr       = nd_rd_data.left;
               end
            end
         end
         S_QROOT: begin
            root_rd_en   = 1'b1;
            root_rd_addr = hi_ff + 1'b1;
         end
         S_QNA: begin
            nd_rd_en   = 1'b1;
            nd_rd_addr = a_idx_ff;
         end
         S_QNB: begin
            nd_rd_en   = 1'b1;
            nd_rd_addr = b_idx_ff;
         end
         S_QCALC: begin
            nd_rd_en   = !last_lvl;
            nd_rd_addr = bit_now ? a_data_ff.right : a_data_ff.left;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (root_wr_en) begin
         root_mem[RB'(items_ff) + 1'b1] <= next_free_ff;
      end
      if (root_rd_en) begin
         root_q_ff    <= root_mem[root_rd_addr];
         root_zero_ff <= (root_rd_addr == '0);
      end
   end

   prct_node_ram u_node_ram (
      .clock   (clock),
      .rd_en   (nd_rd_en),
      .rd_addr (nd_rd_addr),
      .rd_data (nd_rd_data),
      .wr_en   (nd_wr_en),
      .wr_addr (cur_ff),
      .wr_data (nd_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         items_ff     <= '0;
         next_free_ff <= NB'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  hi_ff       <= RB'(req_range_end);
                  depth_ff    <= '0;
                  acc_ff      <= '0;
                  prev_bit_ff <= 1'b1;
                  res_count_ff <= '0;
                  if (req_type == prct_pkg::REQ_APPEND) begin
                     val_ff <= req_item_value[VB-1:0];
                     if (items_ff == CB'(prct_pkg::MAX_ITEMS)) begin
                        res_status_ff <= prct_pkg::STATUS_FULL;
                        state_ff      <= S_OUT;
                     end else begin
                        res_status_ff <= prct_pkg::STATUS_OK;
                        state_ff      <= S_AROOT;
                     end
                  end else begin
                     val_ff <= req_threshold[VB-1:0];
                     if (q_bad) begin
                        res_status_ff <= prct_pkg::STATUS_BAD;
                        state_ff      <= S_OUT;
                     end else begin
                        res_status_ff <= prct_pkg::STATUS_OK;
                        state_ff      <= S_QROOT;
                     end
                  end
               end
            end
            S_AROOT: begin
               cur_ff   <= next_free_ff;
               state_ff <= S_AW;
            end
            S_AW: begin
               cur_ff   <= cur_ff + 1'b1;
               depth_ff <= depth_ff + 1'b1;
               val_ff   <= val_ff << 1;
               if (last_lvl) begin
                  items_ff     <= items_ff + 1'b1;
                  next_free_ff <= next_free_ff + NB'(VB + 1);
                  state_ff     <= S_OUT;
               end
            end
            S_QROOT: begin
               a_idx_ff <= root_eff;
               state_ff <= S_QNA;
            end
            S_QNA: begin
               b_idx_ff <= root_eff;
               state_ff <= S_QNB;
            end
            S_QNB: begin
               a_data_ff <= nd_rd_data;
               state_ff  <= S_QCALC;
            end
            S_QCALC: begin
               acc_ff      <= acc_in;
               prev_bit_ff <= bit_now;
               val_ff      <= val_ff << 1;
               depth_ff    <= depth_ff + 1'b1;
               b_idx_ff    <= bit_now ? nd_rd_data.right : nd_rd_data.left;
               if (last_lvl) begin
                  res_count_ff <= acc_in;
                  state_ff     <= S_OUT;
               end else begin
                  state_ff <= S_QNB;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_count_ff  <= 11'(res_count_ff);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   a_items_bound: assert property (@(posedge clock) disable iff (reset)
      items_ff <= CB'(prct_pkg::MAX_ITEMS))
      else $error("item count beyond capacity");

   a_pool_track: assert property (@(posedge clock) disable iff (reset)
      32'(next_free_ff) == 32'(1) + 32'(items_ff) * 32'(VB + 1))
      else $error("free node pointer out of step with item count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_count_ff} <= 12'(items_ff)))
      else $error("result count exceeds stored items");

endmodule

// ----- tb/tb_persistent_range_count_tree_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_persistent_range_count_tree_top
// Random and directed appends and range-count queries. Checks each response
// against a scoreboard that tracks every stored value in sequence order.
// ----------------------------------------------------------------------------

class range_count_board;
   logic [15:0] seq_vals[$];
   logic [10:0] exp_count[$];
   logic [1:0]  exp_status[$];
   int          errors;

   function void add_result(logic [10:0] cnt, logic [1:0] st);
      exp_count  = {exp_count, cnt};
      exp_status = {exp_status, st};
   endfunction

   function void note_beat(logic typ, logic [15:0] val, logic [9:0] lo, logic [9:0] hi,
                           logic [15:0] thr);
      int n;
      n = 0;
      if (typ == prct_pkg::REQ_APPEND) begin
         if (seq_vals.size() >= prct_pkg::MAX_ITEMS) begin
            add_result('0, prct_pkg::STATUS_FULL);
         end else begin
            seq_vals = {seq_vals, val};
            add_result('0, prct_pkg::STATUS_OK);
         end
      end else if (lo > hi || hi >= seq_vals.size()) begin
         add_result('0, prct_pkg::STATUS_BAD);
      end else begin
         for (int i = lo; i <= hi; i++)
            if (seq_vals[i] > thr) n++;
         add_result(n[10:0], prct_pkg::STATUS_OK);
      end
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_beat(logic [10:0] cnt, logic [1:0] st);
      logic [10:0] ec;
      logic [1:0]  es;
      if (exp_count.size() == 0) begin
         report($sformatf("unexpected beat count=%0d status=%0d", cnt, st));
         return;
      end
      ec = exp_count.pop_front();
      es = exp_status.pop_front();
      if (cnt !== ec) report($sformatf("count %0d, want %0d", cnt, ec));
      if (st !== es) report($sformatf("status %0d, want %0d", st, es));
   endtask

   function int pending();
      return exp_count.size();
   endfunction
endclass

module tb_persistent_range_count_tree_top;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_type = 0;
   logic [15:0] req_item_value = 0;
   logic [9:0]  req_range_start = 0;
   logic [9:0]  req_range_end = 0;
   logic [15:0] req_threshold = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [10:0] rsp_count;
   logic [1:0]  rsp_status;

   range_count_board board = new();
   longint cycles = 0;
   bit     hold_rsp = 0;
   bit     stim_done = 0;

   always #4 clock = ~clock;

   persistent_range_count_tree_top dut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side: random stalls, long hold-off on request
   initial begin
      int w;
      @(posedge clock iff !reset);
      forever begin
         w = $urandom_range(0, 4);
         if ($urandom_range(0, 3) == 0) w = 0;
         if (w != 0 || hold_rsp) begin
            rsp_ready <= 0;
            repeat (w) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock iff rsp_valid);
         board.check_beat(rsp_count, rsp_status);
      end
   end

   task automatic send(logic typ, logic [15:0] val, logic [9:0] lo, logic [9:0] hi,
                       logic [15:0] thr, int gap);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= typ;
      req_item_value <= val;
      req_range_start <= lo;
      req_range_end <= hi;
      req_threshold <= thr;
      @(posedge clock iff req_ready);
      board.note_beat(typ, val, lo, hi, thr);
   endtask

   task automatic rand_item(int gap);
      int n;
      logic [9:0] lo, hi;
      logic [15:0] thr;
      n = board.seq_vals.size();
      if ($urandom_range(0, 2) == 0 && n < prct_pkg::MAX_ITEMS) begin
         send(prct_pkg::REQ_APPEND, 16'($urandom), 10'($urandom), 10'($urandom),
              16'($urandom), gap);
      end else begin
         if (n > 0 && $urandom_range(0, 9) != 0) begin
            hi = 10'($urandom_range(0, n - 1));
            lo = 10'($urandom_range(0, hi));
            if ($urandom_range(0, 3) == 0) lo = 10'($urandom_range(0, hi < 8 ? hi : 8));
         end else begin
            lo = 10'($urandom);
            hi = 10'($urandom);
         end
         thr = 16'($urandom);
         if (n > 0 && $urandom_range(0, 1) == 1)
            thr = board.seq_vals[$urandom_range(0, n - 1)];
         send(prct_pkg::REQ_QUERY, 16'($urandom), lo, hi, thr, gap);
      end
   endtask

   initial begin
      int g;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty query, extremes, bad ranges
      send(prct_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
      send(prct_pkg::REQ_APPEND, 16'hFFFF, 10'h3FF, 10'h3FF, 16'hFFFF, 0);
      send(prct_pkg::REQ_APPEND, 16'h0000, 0, 0, 0, 0);
      send(prct_pkg::REQ_APPEND, 16'h8000, 0, 0, 0, 1);
      send(prct_pkg::REQ_APPEND, 16'h5555, 0, 0, 0, 0);
      send(prct_pkg::REQ_APPEND, 16'hAAAA, 0, 0, 0, 0);
      send(prct_pkg::REQ_QUERY, 16'hFFFF, 0, 4, 16'h0000, 0);
      send(prct_pkg::REQ_QUERY, 0, 0, 4, 16'hFFFF, 0);
      send(prct_pkg::REQ_QUERY, 0, 0, 4, 16'hFFFE, 2);
      send(prct_pkg::REQ_QUERY, 0, 1, 3, 16'h7FFF, 0);
      send(prct_pkg::REQ_QUERY, 0, 3, 1, 0, 0);
      send(prct_pkg::REQ_QUERY, 0, 0, 5, 0, 0);
      send(prct_pkg::REQ_QUERY, 0, 10'h3FF, 10'h3FF, 0, 0);
      send(prct_pkg::REQ_QUERY, 0, 2, 2, 16'h5555, 0);
      send(prct_pkg::REQ_QUERY, 0, 4, 4, 16'h5555, 0);
      // long receiver hold-off while offering beats
      hold_rsp = 1;
      fork
         begin repeat (300) @(posedge clock); hold_rsp = 0; end
         for (int i = 0; i < 20; i++) rand_item(0);
      join
      req_valid <= 0;
      // pause until drained
      while (board.pending() != 0) @(posedge clock);
      for (int i = 0; i < 150; i++) begin
         g = (i % 200 < 40) ? 0 : $urandom_range(0, 4);
         rand_item(g);
      end
      // fill to full, then refused appends and full-range queries
      while (board.seq_vals.size() < prct_pkg::MAX_ITEMS)
         send(prct_pkg::REQ_APPEND, 16'($urandom), 0, 0, 0, 0);
      send(prct_pkg::REQ_APPEND, 16'($urandom), 0, 0, 0, 0);
      send(prct_pkg::REQ_APPEND, 16'hFFFF, 0, 0, 0, 0);
      send(prct_pkg::REQ_QUERY, 0, 0, 10'h3FF, 0, 0);
      send(prct_pkg::REQ_QUERY, 0, 0, 10'h3FF, 16'h7FFF, 0);
      send(prct_pkg::REQ_QUERY, 0, 10'h3FF, 10'h3FF, 0, 0);
      for (int i = 0; i < 30; i++) rand_item($urandom_range(0, 4));
      req_valid <= 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- files.f -----
sv/prct_pkg.sv
sv/prct_node_ram.sv
sv/persistent_range_count_tree_top.sv
tb/tb_persistent_range_count_tree_top.sv
